@@ rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the comment span scanner.
// ----------------------------------------------------------------------------
package csc_pkg;

    // counter widths
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // packed output beat: line, column, length, zero fill to whole bytes
    localparam int SPAN_BITS   = LINE_BITS + 2 * COLUMN_BITS;
    localparam int TDATA_BITS  = ((SPAN_BITS + 7) / 8) * 8;

    // byte codes the scanner reacts to
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_STAR    = 8'h2A;
    localparam logic [7:0] C_DQUOTE  = 8'h22;
    localparam logic [7:0] C_SQUOTE  = 8'h27;
    localparam logic [7:0] C_BSLASH  = 8'h5C;

    // scanner mode
    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_DQ,
        MODE_DQ_ESC,
        MODE_SQ,
        MODE_SQ_ESC
    } t_mode;

    // full scanner state
    typedef struct packed {
        t_mode                  mode;
        logic                   cr_seen;
        logic [LINE_BITS-1:0]   cur_line;
        logic [COLUMN_BITS-1:0] cur_col;
        logic [LINE_BITS-1:0]   p_line;
        logic [COLUMN_BITS-1:0] p_col;
        logic [COLUMN_BITS-1:0] p_len;
    } t_state;

    // one reported comment piece
    typedef struct packed {
        logic [COLUMN_BITS-1:0] len;
        logic [COLUMN_BITS-1:0] col;
        logic [LINE_BITS-1:0]   line;
    } t_span;

    localparam t_state STATE_RESET = '{
        mode:     MODE_NORMAL,
        cr_seen:  1'b0,
        cur_line: '0,
        cur_col:  '0,
        p_line:   '0,
        p_col:    '0,
        p_len:    '0
    };

endpackage

@@ rtl/csc_step.sv @@
// ----------------------------------------------------------------------------
// csc_step
// Next-state and result logic of the scanner for one text byte.
// ----------------------------------------------------------------------------
module csc_step (
    input  csc_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output csc_pkg::t_state o_state,
    output logic            o_emit,
    output csc_pkg::t_span  o_span
);

    // saturating increments
    function automatic logic [csc_pkg::LINE_BITS-1:0] sat_line(
        input logic [csc_pkg::LINE_BITS-1:0] v
    );
        sat_line = (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [csc_pkg::COLUMN_BITS-1:0] sat_col(
        input logic [csc_pkg::COLUMN_BITS-1:0] v
    );
        sat_col = (&v) ? v : v + 1'b1;
    endfunction

    // plain text handling (caller sets the mode to normal first)
    function automatic csc_pkg::t_state do_normal(
        input csc_pkg::t_state s,
        input logic [7:0]      b
    );
        csc_pkg::t_state r;
        r = s;
        if (b == csc_pkg::C_LF || b == csc_pkg::C_CR) begin
            r.cur_line = sat_line(s.cur_line);
            r.cur_col  = '0;
            if (b == csc_pkg::C_CR) begin
                r.cr_seen = 1'b1;
            end
        end else if (b == csc_pkg::C_SLASH) begin
            r.p_line  = s.cur_line;
            r.p_col   = s.cur_col;
            r.cur_col = sat_col(s.cur_col);
            r.mode    = csc_pkg::MODE_SLASH;
        end else if (b == csc_pkg::C_DQUOTE) begin
            r.cur_col = sat_col(s.cur_col);
            r.mode    = csc_pkg::MODE_DQ;
        end else if (b == csc_pkg::C_SQUOTE) begin
            r.cur_col = sat_col(s.cur_col);
            r.mode    = csc_pkg::MODE_SQ;
        end else begin
            r.cur_col = sat_col(s.cur_col);
        end
        return r;
    endfunction

    // inside a block comment (caller sets the mode to block first)
    function automatic csc_pkg::t_state do_block(
        input csc_pkg::t_state s,
        input logic [7:0]      b
    );
        csc_pkg::t_state r;
        r = s;
        if (b == csc_pkg::C_LF || b == csc_pkg::C_CR) begin
            r.cur_line = sat_line(s.cur_line);
            r.cur_col  = '0;
            if (b == csc_pkg::C_CR) begin
                r.cr_seen = 1'b1;
            end
            r.p_line = r.cur_line;
            r.p_col  = '0;
            r.p_len  = '0;
        end else begin
            r.cur_col = sat_col(s.cur_col);
            r.p_len   = sat_col(s.p_len);
            if (b == csc_pkg::C_STAR) begin
                r.mode = csc_pkg::MODE_BLOCK_STAR;
            end
        end
        return r;
    endfunction

    // inside a quoted literal
    function automatic csc_pkg::t_state do_literal(
        input csc_pkg::t_state s,
        input logic [7:0]      b,
        input logic [7:0]      quote,
        input csc_pkg::t_mode  esc_mode
    );
        csc_pkg::t_state r;
        r = s;
        if (b == csc_pkg::C_LF) begin
            r.mode = csc_pkg::MODE_NORMAL;
            r      = do_normal(r, b);
        end else begin
            r.cur_col = sat_col(s.cur_col);
            if (b == quote) begin
                r.mode = csc_pkg::MODE_NORMAL;
            end else if (b == csc_pkg::C_BSLASH) begin
                r.mode = esc_mode;
            end
        end
        return r;
    endfunction

    csc_pkg::t_state w_s;
    csc_pkg::t_state w_n;
    logic            w_is_nl;
    logic            w_absorb;
    logic            w_emit;
    csc_pkg::t_span  w_span;

    assign w_is_nl  = (i_byte == csc_pkg::C_LF) || (i_byte == csc_pkg::C_CR);
    assign w_absorb = i_state.cr_seen && (i_byte == csc_pkg::C_LF) &&
                      (i_state.mode == csc_pkg::MODE_NORMAL ||
                       i_state.mode == csc_pkg::MODE_BLOCK);

    // per-mode byte handling
    always_comb begin
        w_s         = i_state;
        w_s.cr_seen = 1'b0;
        w_n         = w_s;
        w_emit      = 1'b0;
        w_span      = '{len: i_state.p_len, col: i_state.p_col, line: i_state.p_line};
        if (!w_absorb) begin
            unique case (w_s.mode)
                csc_pkg::MODE_SLASH: begin
                    if (i_byte == csc_pkg::C_SLASH || i_byte == csc_pkg::C_STAR) begin
                        w_n.cur_col = sat_col(w_s.cur_col);
                        w_n.p_len   = csc_pkg::COLUMN_BITS'(2);
                        w_n.mode    = (i_byte == csc_pkg::C_SLASH) ?
                                      csc_pkg::MODE_LINE : csc_pkg::MODE_BLOCK;
                    end else begin
                        w_n.mode = csc_pkg::MODE_NORMAL;
                        w_n      = do_normal(w_n, i_byte);
                    end
                end
                csc_pkg::MODE_LINE: begin
                    if (w_is_nl) begin
                        w_emit   = (w_s.p_len != '0);
                        w_n.mode = csc_pkg::MODE_NORMAL;
                        w_n      = do_normal(w_n, i_byte);
                    end else begin
                        w_n.cur_col = sat_col(w_s.cur_col);
                        w_n.p_len   = sat_col(w_s.p_len);
                    end
                end
                csc_pkg::MODE_BLOCK: begin
                    w_emit = w_is_nl && (w_s.p_len != '0);
                    w_n    = do_block(w_s, i_byte);
                end
                csc_pkg::MODE_BLOCK_STAR: begin
                    if (i_byte == csc_pkg::C_SLASH) begin
                        w_n.cur_col = sat_col(w_s.cur_col);
                        w_n.p_len   = sat_col(w_s.p_len);
                        w_n.mode    = csc_pkg::MODE_NORMAL;
                        w_emit      = (w_n.p_len != '0);
                        w_span.len  = w_n.p_len;
                    end else begin
                        w_emit   = w_is_nl && (w_s.p_len != '0);
                        w_n.mode = csc_pkg::MODE_BLOCK;
                        w_n      = do_block(w_n, i_byte);
                    end
                end
                csc_pkg::MODE_DQ: begin
                    w_n = do_literal(w_s, i_byte, csc_pkg::C_DQUOTE, csc_pkg::MODE_DQ_ESC);
                end
                csc_pkg::MODE_SQ: begin
                    w_n = do_literal(w_s, i_byte, csc_pkg::C_SQUOTE, csc_pkg::MODE_SQ_ESC);
                end
                csc_pkg::MODE_DQ_ESC: begin
                    w_n.cur_col = sat_col(w_s.cur_col);
                    w_n.mode    = csc_pkg::MODE_DQ;
                end
                csc_pkg::MODE_SQ_ESC: begin
                    w_n.cur_col = sat_col(w_s.cur_col);
                    w_n.mode    = csc_pkg::MODE_SQ;
                end
                default: begin
                    w_n.mode = csc_pkg::MODE_NORMAL;
                    w_n      = do_normal(w_n, i_byte);
                end
            endcase
        end
    end

    // end of text: flush an open line comment, then return to reset state
    always_comb begin
        o_emit  = w_emit;
        o_span  = w_span;
        o_state = w_n;
        if (i_last) begin
            if (w_n.mode == csc_pkg::MODE_LINE && !w_emit) begin
                o_emit = (w_n.p_len != '0);
                o_span = '{len: w_n.p_len, col: w_n.p_col, line: w_n.p_line};
            end
            o_state = csc_pkg::STATE_RESET;
        end
    end

endmodule

@@ rtl/comment_span_scanner.sv @@
// ----------------------------------------------------------------------------
// comment_span_scanner
// Streams source text byte by byte and reports line, column and length of
// every comment piece.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                         | tlast
//  ----------+-----+-------------------------------+----------------------
//  s_axis    | in  | [7:0] text byte               | last byte of the text
//  m_axis    | out | [19:0] line [35:20] column    | unused
//            |     | [51:36] length [55:52] zero   |
//
//  one byte a cycle unless a result stalls; a byte goes input register ->
//  scan logic -> result register, which drives m_axis.
//  reset returns the scanner to plain text at line 0, column 0 and empties
//  both registers. a stalled result holds the result register and the byte
//  behind it; input keeps flowing while the result is taken each cycle.
// ----------------------------------------------------------------------------
module comment_span_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input text stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] text_byte
    input  logic                           i_s_axis_tlast,  // final_byte
    // comment piece stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [19:0] span_line, [35:20] span_column, [51:36] span_length, rest zero
    output logic [csc_pkg::TDATA_BITS-1:0] o_m_axis_tdata
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    logic            r_out_valid;
    csc_pkg::t_span  r_out_span;
    csc_pkg::t_state r_state;

    csc_pkg::t_state w_next_state;
    logic            w_emit;
    csc_pkg::t_span  w_span;
    logic            w_out_free;
    logic            w_advance;

    // handshake
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // scan logic
    csc_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (w_next_state),
        .o_emit  (w_emit),
        .o_span  (w_span)
    );

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csc_pkg::STATE_RESET;
        end else if (w_advance) begin
            r_state <= w_next_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_span <= w_span;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = csc_pkg::TDATA_BITS'(r_out_span);

endmodule

@@ rtl/csc_checker.sv @@
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks of the comment span scanner, bound to the top level.
// ----------------------------------------------------------------------------
module csc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           i_s_axis_tready,
    input logic                           i_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [csc_pkg::TDATA_BITS-1:0] i_m_axis_tdata
);

    // a stalled result beat stays valid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> $stable(i_m_axis_tdata))
        else $error("result payload changed while stalled");

    // a reported piece is never empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |->
            i_m_axis_tdata[csc_pkg::SPAN_BITS-1:csc_pkg::LINE_BITS+csc_pkg::COLUMN_BITS]
            != '0)
        else $error("zero-length piece reported");

    // with no result waiting the scanner always takes text
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_axis_tvalid |-> i_s_axis_tready)
        else $error("input stalled with empty result register");

    // no result appears without earlier input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_axis_tvalid) |-> $past(i_s_axis_tvalid, 2) || $past(!i_s_axis_tready, 2)
                                   || $past(!i_s_axis_tready))
        else $error("result beat without preceding text");

endmodule

bind comment_span_scanner csc_checker u_csc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
